// ----- hdl/sst_pkg.sv -----
`timescale 1ns / 1ps
package sst_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int NAME_BYTES = 8;

  localparam int NAME_W = NAME_BYTES * 8;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int OP_W = 3;
  localparam int IN_NAME_W = 64;
  localparam int DEPTH_W = 8;
  localparam int FIELD_W = 8;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH      = 3'd0,
    OP_PUSH_TEMP = 3'd1,
    OP_POP       = 3'd2,
    OP_CLR_TEMP  = 3'd3,
    OP_LOOKUP    = 3'd4,
    OP_QUERY     = 3'd5,
    OP_SET_INIT  = 3'd6,
    OP_CLR_DEEP  = 3'd7
  } op_e;

  // entry write, broadcast to all cells
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [NAME_W-1:0]  name;
    logic               is_const;
    logic [DEPTH_W-1:0] depth;
  } wr_t;

  // search key, held for the whole walk
  typedef struct packed {
    op_e                op;
    logic [NAME_W-1:0]  name;
    logic [DEPTH_W-1:0] depth;
    logic [CNT_W-1:0]   count;
  } key_t;

  // token that walks from cell 0 to the last cell
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             hit_init;
    logic [CNT_W-1:0] keep;
  } probe_t;

endpackage

// ----- hdl/sst_cell.sv -----
`timescale 1ns / 1ps
module sst_cell
  import sst_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  wr_t              wr_i,
  input  key_t             key_i,
  input  probe_t           probe_i,
  output probe_t           probe_o
);

  logic [NAME_W-1:0]  name_q;
  logic               const_q;
  logic               init_q;
  logic [DEPTH_W-1:0] depth_q;
  probe_t             probe_d, probe_q;
  logic               live, match, first;

  always_comb begin
    live    = {1'b0, idx_i} < key_i.count;
    match   = live && (name_q == key_i.name) && (depth_q == key_i.depth);
    first   = probe_i.valid && match && !probe_i.hit;
    probe_d = probe_i;
    if (first) begin
      probe_d.hit      = 1'b1;
      probe_d.hit_idx  = idx_i;
      probe_d.hit_init = init_q | (key_i.op == OP_SET_INIT);
    end
    // last named entry not deeper than the key depth so far
    if (live && (depth_q <= key_i.depth)) begin
      probe_d.keep = {1'b0, idx_i} + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == idx_i)) begin
      name_q  <= wr_i.name;
      const_q <= wr_i.is_const;
      depth_q <= wr_i.depth;
      init_q  <= 1'b0;
    end else if (first && (key_i.op == OP_SET_INIT)) begin
      init_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign probe_o = probe_q;

endmodule

// ----- hdl/sst_ctrl.sv -----
`timescale 1ns / 1ps
module sst_ctrl
  import sst_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [IN_NAME_W-1:0] name_i,
  input  logic                 is_const_i,
  input  logic [DEPTH_W-1:0]   depth_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [FIELD_W-1:0]   address_o,
  output logic                 init_flag_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [FIELD_W-1:0]   temp_index_o,
  output wr_t                  wr_o,
  output key_t                 key_o,
  output probe_t               launch_o,
  input  probe_t               probe_i
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic [FIELD_W-1:0] address;
    logic               init_flag;
    status_e            status;
    logic [FIELD_W-1:0] temp_index;
  } res_t;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  // one past the next free temporary slot, so an exhausted top reads as zero
  logic [CNT_W-1:0]   tmp_q, tmp_d;
  logic [CNT_W-1:0]   tmp_m1;
  key_t               key_q, key_d;
  logic               launch_q, launch_d;
  res_t               out_q, out_d, pend_q, pend_d, res;
  logic               out_valid_q, out_valid_d, pend_valid_q, pend_valid_d;
  logic               accept, out_take, res_valid, full;
  op_e                in_op;

  assign in_stall_o = (state_q != ST_IDLE) || pend_valid_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign in_op      = op_e'(op_i);
  assign full       = count_q >= tmp_q;
  assign tmp_m1     = tmp_q - CNT_W'(1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    tmp_d     = tmp_q;
    key_d     = key_q;
    launch_d  = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    wr_o      = '0;
    wr_o.name     = name_i[NAME_W-1:0];
    wr_o.is_const = is_const_i;
    wr_o.depth    = depth_i;

    if (state_q == ST_IDLE) begin
      if (accept) begin
        res_valid = 1'b1;
        case (in_op)
          OP_PUSH: begin
            if (full) begin
              res.status = STAT_FULL;
            end else begin
              wr_o.en     = 1'b1;
              wr_o.idx    = count_q[IDX_W-1:0];
              res.address = FIELD_W'(count_q);
              count_d     = count_q + CNT_W'(1);
            end
          end
          OP_PUSH_TEMP: begin
            if (full) begin
              res.status = STAT_FULL;
            end else begin
              wr_o.en     = 1'b1;
              wr_o.idx    = tmp_m1[IDX_W-1:0];
              res.address = FIELD_W'(tmp_m1);
              tmp_d       = tmp_m1;
            end
          end
          OP_POP: begin
            if (count_q != '0) count_d = count_q - CNT_W'(1);
          end
          OP_CLR_TEMP: begin
            tmp_d = CNT_W'(TABLE_ENTRIES);
          end
          default: begin
            // lookup, query, set and clear-deeper walk the cell chain
            res_valid   = 1'b0;
            key_d.op    = in_op;
            key_d.name  = name_i[NAME_W-1:0];
            key_d.depth = depth_i;
            key_d.count = count_q;
            launch_d    = 1'b1;
            state_d     = ST_SCAN;
          end
        endcase
      end
    end else if (probe_i.valid) begin
      res_valid = 1'b1;
      state_d   = ST_IDLE;
      if (key_q.op == OP_CLR_DEEP) begin
        count_d = probe_i.keep;
      end else if (probe_i.hit) begin
        res.address   = FIELD_W'(probe_i.hit_idx);
        res.init_flag = probe_i.hit_init;
      end else begin
        res.status = STAT_NOT_FOUND;
      end
    end
    res.temp_index = (tmp_d == '0) ? '1 : FIELD_W'(tmp_d - CNT_W'(1));
  end

  // output register with one skid entry behind it
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    if (!out_valid_q || out_take) begin
      if (pend_valid_q) begin
        out_d        = pend_q;
        out_valid_d  = 1'b1;
        pend_d       = res;
        pend_valid_d = res_valid;
      end else begin
        out_d       = res;
        out_valid_d = res_valid;
      end
    end else if (res_valid) begin
      pend_d       = res;
      pend_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      tmp_q        <= CNT_W'(TABLE_ENTRIES);
      key_q        <= '0;
      launch_q     <= 1'b0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      tmp_q        <= tmp_d;
      key_q        <= key_d;
      launch_q     <= launch_d;
      out_q        <= out_d;
      out_valid_q  <= out_valid_d;
      pend_q       <= pend_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_comb begin
    launch_o          = '0;
    launch_o.valid    = launch_q;
    launch_o.hit_init = 1'b0;
  end

  assign key_o        = key_q;
  assign out_valid_o  = out_valid_q;
  assign address_o    = out_q.address;
  assign init_flag_o  = out_q.init_flag;
  assign status_o     = out_q.status;
  assign temp_index_o = out_q.temp_index;

  a_named_below_temps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= tmp_q)
    else $error("named entries overlap the temporary region");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_probe_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (probe_i.valid || launch_q) |-> (state_q == ST_SCAN))
    else $error("probe in flight outside a scan");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && probe_i.valid) |=> (state_q == ST_IDLE))
    else $error("scan did not finish when the probe returned");

endmodule

// ----- hdl/scoped_symbol_stack_table.sv -----
`timescale 1ns / 1ps
// push, push temp, pop and clear temps compute their result at accept and register it for the output
// lookup, query, set init and clear deeper give their result when the probe returns,
//   after walking the cell chain from cell 0 to the last cell, one cell per cycle
// throughput: one transaction in flight; a short op allows the next accept the next cycle unless the skid entry is held
// reset: no named entries, temporary top at the last entry, entry storage not cleared
module scoped_symbol_stack_table
  import sst_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [IN_NAME_W-1:0] name_i,
  input  logic                 is_const_i,
  input  logic [DEPTH_W-1:0]   depth_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [FIELD_W-1:0]   address_o,
  output logic                 init_flag_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [FIELD_W-1:0]   temp_index_o
);

  wr_t    wr;
  key_t   key;
  probe_t chain [TABLE_ENTRIES+1];

  sst_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .name_i       (name_i),
    .is_const_i   (is_const_i),
    .depth_i      (depth_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .address_o    (address_o),
    .init_flag_o  (init_flag_o),
    .status_o     (status_o),
    .temp_index_o (temp_index_o),
    .wr_o         (wr),
    .key_o        (key),
    .launch_o     (chain[0]),
    .probe_i      (chain[TABLE_ENTRIES])
  );

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    sst_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(g)),
      .wr_i    (wr),
      .key_i   (key),
      .probe_i (chain[g]),
      .probe_o (chain[g+1])
    );
  end

endmodule
